@@ rtl/core/wkss_pkg.sv @@
// ----------------------------------------------------------------------------
// wkss_pkg
// Shared types and constants for the sliding window k-smallest sum filter.
// ----------------------------------------------------------------------------
package wkss_pkg;

    localparam int SUM_W    = 40;
    localparam int CFG_W    = 9;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic REG_WINDOW_LEN     = 1'b0;
    localparam logic REG_SMALLEST_COUNT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_REMOVE,
        S_INSERT,
        S_SUM,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic remove;
        logic insert;
    } t_cell_cmd;

endpackage

@@ rtl/core/wkss_if.sv @@
// ----------------------------------------------------------------------------
// wkss_if
// Valid/ready channels: sample items in, window sum items out.
// ----------------------------------------------------------------------------
interface wkss_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample;
    logic        restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface wkss_out_if;
    logic        valid;
    logic        ready;
    logic [39:0] window_sum;

    modport source (output valid, output window_sum, input ready);
    modport sink   (input valid, input window_sum, output ready);
endinterface

@@ rtl/core/window_k_smallest_sum_top.sv @@
// ----------------------------------------------------------------------------
// window_k_smallest_sum_top
// Sliding window filter: sum of the smallest samples over the last N samples.
// ----------------------------------------------------------------------------
// Flow: a result follows item accept once the sum token has walked k cells of
//   the sorted chain (k = clamped count); items that give no result return to
//   idle after the insert. One item in flight at a time.
// Reset (sync, active low): window empty, window_len = 8, smallest_count = 4.
// ----------------------------------------------------------------------------
module window_k_smallest_sum_top #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    wkss_in_if.sink                       i_smp,
    wkss_out_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wkss_pkg::PADDR_W-1:0]  paddr,
    input  logic [wkss_pkg::PDATA_W-1:0]  pwdata,
    output logic [wkss_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import wkss_pkg::*;

    localparam int WB = $clog2(MAX_WINDOW + 1);
    localparam int PB = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SB = SAMPLE_BITS;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_wlen, r_kcnt;
    logic [WB-1:0]     r_fill, n_fill;
    logic [PB-1:0]     r_ptr, n_ptr;
    logic [SB-1:0]     r_s;
    logic              r_rst;
    logic [SUM_W-1:0]  r_res, n_res;
    logic              r_out_vld;
    logic [SUM_W-1:0]  r_out_sum;

    logic [WB-1:0]     w_eff, k_eff;
    logic              cfg_wr;
    logic              empty_win;
    logic [PB-1:0]     ptr_prep;
    logic [PB-1:0]     ptr_inc;
    logic              out_load;
    logic              start;
    t_cell_cmd         cmd;
    logic              ring_we;
    logic [SB-1:0]     ring_rdata;
    logic              any_hit;
    logic [SUM_W-1:0]  hit_sum;

    logic [SB-1:0]     c_val  [MAX_WINDOW];
    logic              c_vld  [MAX_WINDOW];
    logic              c_gt   [MAX_WINDOW];
    logic              c_tok  [MAX_WINDOW];
    logic [SUM_W-1:0]  c_acc  [MAX_WINDOW];
    logic              c_hit  [MAX_WINDOW];
    logic [SUM_W-1:0]  c_hacc [MAX_WINDOW];

    // configuration
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SMALLEST_COUNT) ? PDATA_W'(r_kcnt) : PDATA_W'(r_wlen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= CFG_W'(8);
            r_kcnt <= CFG_W'(4);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WINDOW_LEN) begin
                r_wlen <= pwdata[CFG_W-1:0];
            end else begin
                r_kcnt <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        if (r_wlen == '0) begin
            w_eff = WB'(1);
        end else if (32'(r_wlen) > 32'(MAX_WINDOW)) begin
            w_eff = WB'(MAX_WINDOW);
        end else begin
            w_eff = WB'(r_wlen);
        end
        if (32'(r_kcnt) < 32'(w_eff)) begin
            k_eff = WB'(r_kcnt);
        end else begin
            k_eff = w_eff;
        end
    end

    assign empty_win = r_rst || (r_fill > w_eff);
    always_comb begin
        ptr_prep = empty_win ? '0 : r_ptr;
        if (WB'(ptr_prep) >= w_eff) begin
            ptr_prep = '0;
        end
    end
    assign ptr_inc = (WB'(r_ptr) + WB'(1) == w_eff) ? '0 : PB'(r_ptr + PB'(1));

    assign out_load = (r_state == S_DONE) && (!r_out_vld || o_res.ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_smp.valid) n_state = S_PREP;
            S_PREP:   n_state = S_REMOVE;
            S_REMOVE: n_state = S_INSERT;
            S_INSERT: begin
                if (r_fill + WB'(1) != w_eff) begin
                    n_state = S_IDLE;
                end else if (k_eff == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SUM;
                end
            end
            S_SUM:    if (any_hit) n_state = S_DONE;
            S_DONE:   if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        n_fill  = r_fill;
        n_ptr   = r_ptr;
        n_res   = r_res;
        cmd     = '0;
        ring_we = 1'b0;
        start   = 1'b0;
        case (r_state)
            S_PREP: begin
                n_fill    = empty_win ? '0 : r_fill;
                n_ptr     = ptr_prep;
                cmd.clear = empty_win;
            end
            S_REMOVE: begin
                if (r_fill == w_eff) begin
                    cmd.remove = 1'b1;
                    n_fill     = r_fill - WB'(1);
                end
                ring_we = 1'b1;
                n_ptr   = ptr_inc;
            end
            S_INSERT: begin
                cmd.insert = 1'b1;
                n_fill     = r_fill + WB'(1);
                n_res      = '0;
                start      = (r_fill + WB'(1) == w_eff) && (k_eff != '0);
            end
            S_SUM: begin
                if (any_hit) n_res = hit_sum;
            end
            default: ;
        endcase
        if (cfg_wr) begin
            n_fill    = '0;
            n_ptr     = '0;
            cmd.clear = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_ptr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ptr   <= n_ptr;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_smp.valid) begin
            r_s   <= i_smp.sample[SB-1:0];
            r_rst <= i_smp.restart;
        end
        r_res <= n_res;
        if (out_load) begin
            r_out_sum <= r_res;
        end
    end

    assign i_smp.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_out_vld;
    assign o_res.window_sum = r_out_sum;

    wkss_ring #(
        .DEPTH (MAX_WINDOW),
        .AW    (PB),
        .DW    (SB)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_ptr),
        .i_wdata (r_s),
        .i_raddr (ptr_prep),
        .o_rdata (ring_rdata)
    );

    // sorted cell chain
    for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
        logic [SB-1:0]    prev_val;
        logic             prev_vld;
        logic             prev_gt;
        logic             prev_tok;
        logic [SUM_W-1:0] prev_acc;
        logic [SB-1:0]    next_val;
        logic             next_vld;

        if (gi == 0) begin : g_first
            assign prev_val = '0;
            assign prev_vld = 1'b1;
            assign prev_gt  = 1'b0;
            assign prev_tok = start;
            assign prev_acc = '0;
        end else begin : g_mid
            assign prev_val = c_val[gi-1];
            assign prev_vld = c_vld[gi-1];
            assign prev_gt  = c_gt[gi-1];
            assign prev_tok = c_tok[gi-1];
            assign prev_acc = c_acc[gi-1];
        end

        if (gi == MAX_WINDOW - 1) begin : g_last
            assign next_val = '0;
            assign next_vld = 1'b0;
        end else begin : g_inner
            assign next_val = c_val[gi+1];
            assign next_vld = c_vld[gi+1];
        end

        wkss_cell #(
            .SB  (SB),
            .WB  (WB),
            .IDX (gi)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_x        (ring_rdata),
            .i_s        (r_s),
            .i_k        (k_eff),
            .i_prev_val (prev_val),
            .i_prev_vld (prev_vld),
            .i_prev_gt  (prev_gt),
            .i_prev_tok (prev_tok),
            .i_prev_acc (prev_acc),
            .i_next_val (next_val),
            .i_next_vld (next_vld),
            .o_val      (c_val[gi]),
            .o_vld      (c_vld[gi]),
            .o_gt       (c_gt[gi]),
            .o_tok      (c_tok[gi]),
            .o_acc      (c_acc[gi]),
            .o_hit      (c_hit[gi]),
            .o_hit_acc  (c_hacc[gi])
        );
    end

    always_comb begin
        any_hit = 1'b0;
        hit_sum = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            any_hit = any_hit | c_hit[i];
            hit_sum = hit_sum | c_hacc[i];
        end
    end
endmodule

@@ rtl/core/wkss_ring.sv @@
// ----------------------------------------------------------------------------
// wkss_ring
// Arrival-order sample history: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wkss_ring #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/wkss_cell.sv @@
// ----------------------------------------------------------------------------
// wkss_cell
// One slot of the sorted window: local remove/insert shift and sum token.
// ----------------------------------------------------------------------------
module wkss_cell #(
    parameter int SB  = 32,
    parameter int WB  = 9,
    parameter int IDX = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wkss_pkg::t_cell_cmd       i_cmd,
    input  logic [SB-1:0]             i_x,
    input  logic [SB-1:0]             i_s,
    input  logic [WB-1:0]             i_k,
    input  logic [SB-1:0]             i_prev_val,
    input  logic                      i_prev_vld,
    input  logic                      i_prev_gt,
    input  logic                      i_prev_tok,
    input  logic [wkss_pkg::SUM_W-1:0] i_prev_acc,
    input  logic [SB-1:0]             i_next_val,
    input  logic                      i_next_vld,
    output logic [SB-1:0]             o_val,
    output logic                      o_vld,
    output logic                      o_gt,
    output logic                      o_tok,
    output logic [wkss_pkg::SUM_W-1:0] o_acc,
    output logic                      o_hit,
    output logic [wkss_pkg::SUM_W-1:0] o_hit_acc
);
    import wkss_pkg::*;

    localparam logic [WB:0] IDX_W  = (WB+1)'(IDX);
    localparam logic [WB:0] IDX_P1 = (WB+1)'(IDX + 1);

    logic [SB-1:0]    r_val, n_val;
    logic             r_vld, n_vld;
    logic             r_tok;
    logic [SUM_W-1:0] r_acc;
    logic             gt;
    logic             shift_out;
    logic             in_k;

    assign gt        = !r_vld || (r_val > i_s);
    assign shift_out = r_vld && ((r_val > i_x) ||
                       ((r_val == i_x) && !(i_next_vld && (i_next_val == i_x))));
    assign in_k      = IDX_W < {1'b0, i_k};

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        if (i_cmd.clear) begin
            n_vld = 1'b0;
        end else if (i_cmd.remove) begin
            if (shift_out) begin
                n_val = i_next_val;
                n_vld = i_next_vld;
            end
        end else if (i_cmd.insert) begin
            if (gt) begin
                n_val = i_prev_gt ? i_prev_val : i_s;
            end
            n_vld = r_vld | i_prev_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_tok <= 1'b0;
        end else begin
            r_vld <= n_vld;
            r_tok <= i_prev_tok;
        end
    end

    // sum the value the slot holds once the insert has landed
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_acc <= i_prev_acc + (in_k ? SUM_W'(n_val) : '0);
    end

    assign o_val     = r_val;
    assign o_vld     = r_vld;
    assign o_gt      = gt;
    assign o_tok     = r_tok;
    assign o_acc     = r_acc;
    assign o_hit     = r_tok && (IDX_P1 == {1'b0, i_k});
    assign o_hit_acc = o_hit ? r_acc : '0;
endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for window_k_smallest_sum_top. Sample items stream in
// through random gaps, and the result channel stalls at random. A scoreboard
// keeps its own window in arrival order and in sorted order and predicts each
// window sum. Register settings cover the default, the smallest and largest
// windows, a zero count and a count above the window.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wkss_pkg::*;

    localparam int MAX_WIN = 256;

    class sum_board;
        logic [31:0]    arrival [MAX_WIN];
        logic [31:0]    ordered [$];
        logic [SUM_W-1:0] sums_due [$];
        int unsigned    ptr;
        logic [8:0]     win_len;
        logic [8:0]     cnt;
        int             errors;
        int             n_samples;
        int             n_sums;
        int             n_restarts;

        function void clear_window();
            ordered.delete();
            ptr = 0;
        endfunction

        function void reset_state();
            clear_window();
            win_len = 9'd8;
            cnt = 9'd4;
        endfunction

        function int unsigned eff_len();
            if (win_len == 0) return 1;
            if (win_len > MAX_WIN) return MAX_WIN;
            return win_len;
        endfunction

        function void write_reg(logic idx, logic [8:0] val);
            if (idx == REG_WINDOW_LEN) win_len = val;
            else cnt = val;
            clear_window();
        endfunction

        function int pending();
            return sums_due.size();
        endfunction

        function void note_sample(logic [31:0] s, logic restart);
            int unsigned w;
            int unsigned k;
            int unsigned pos;
            bit found;
            logic [SUM_W-1:0] acc;
            w = eff_len();
            k = (cnt < w) ? cnt : w;
            n_samples++;
            if (restart) begin
                n_restarts++;
                clear_window();
            end
            if (ordered.size() > w) clear_window();
            if (ptr >= w) ptr = 0;
            if (ordered.size() == w) begin
                found = 0;
                pos = 0;
                foreach (ordered[i]) begin
                    if (!found && ordered[i] == arrival[ptr]) begin
                        pos = i;
                        found = 1;
                    end
                end
                if (!found) pos = ordered.size() - 1;
                ordered.delete(pos);
            end
            arrival[ptr] = s;
            ptr = (ptr + 1 == w) ? 0 : ptr + 1;
            pos = ordered.size();
            while (pos > 0 && ordered[pos-1] > s) pos--;
            ordered.insert(pos, s);
            if (ordered.size() != w) return;
            acc = '0;
            for (int i = 0; i < k; i++) acc = acc + SUM_W'(ordered[i]);
            sums_due.push_back(acc);
        endfunction

        function void check_sum(logic [SUM_W-1:0] actual);
            logic [SUM_W-1:0] want;
            if (sums_due.size() == 0) begin
                $error("window_sum: no item expected, actual %0d", actual);
                errors++;
                return;
            end
            want = sums_due.pop_front();
            n_sums++;
            if (actual !== want) begin
                $error("window_sum: expected %0d, actual %0d", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    wkss_in_if  smp_if ();
    wkss_out_if res_if ();

    sum_board sb;
    bit quiet;
    int hold_cycles;
    int n_settings;
    logic [31:0] last_sample;

    window_k_smallest_sum_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("tb: FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) sb.check_sum(res_if.window_sum);
            if (smp_if.valid && smp_if.ready) sb.note_sample(smp_if.sample, smp_if.restart);
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                res_if.ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            gap = quiet ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
        end
    end

    task automatic send_sample(logic [31:0] s, logic restart);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid   <= 1'b1;
        smp_if.sample  <= s;
        smp_if.restart <= restart;
        do @(posedge i_clk); while (!smp_if.ready);
    endtask

    task automatic reg_write(logic idx, logic [8:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic drain(int extra);
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    function automatic logic [31:0] draw_sample();
        case ($urandom_range(0, 5))
            0: draw_sample = $urandom_range(0, 15);
            1: draw_sample = 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: draw_sample = 32'h0;
            3: draw_sample = last_sample;
            default: draw_sample = $urandom;
        endcase
    endfunction

    task automatic run_phase(logic [8:0] win, logic [8:0] cnt, int n_items, bit q);
        int w;
        logic r;
        reg_write(REG_WINDOW_LEN, win);
        reg_write(REG_SMALLEST_COUNT, cnt);
        n_settings++;
        quiet = q;
        w = (win == 0) ? 1 : (win > MAX_WIN) ? MAX_WIN : win;
        repeat (n_items) begin
            r = ($urandom_range(0, 4 * w + 8) == 0);
            last_sample = draw_sample();
            send_sample(last_sample, r);
        end
        drain(12);
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        quiet = 1'b0;
        hold_cycles = 0;
        n_settings = 1;
        last_sample = '0;
        i_rst_n <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        smp_if.valid   <= 1'b0;
        smp_if.sample  <= '0;
        smp_if.restart <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: window 8, sum of the 4 smallest
        send_sample(32'h0, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0, 1'b0);
        send_sample(32'h5, 1'b0);
        send_sample(32'h5, 1'b0);
        send_sample(32'h5, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h1, 1'b0);
        send_sample(32'h5, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0, 1'b0);
        send_sample(32'h0, 1'b0);
        send_sample(32'h5555_5555, 1'b0);
        send_sample(32'h7, 1'b1);
        send_sample(32'hAAAA_AAAA, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h9, 1'b1);
        repeat (7) send_sample(32'hFFFF_FFFF, 1'b0);
        drain(12);

        run_phase(9'd1,   9'd1,   60,  1'b0);
        run_phase(9'd0,   9'd5,   40,  1'b0);
        run_phase(9'd3,   9'd0,   40,  1'b1);
        run_phase(9'd5,   9'd9,   60,  1'b0);
        run_phase(9'd2,   9'd1,   50,  1'b0);
        hold_cycles = 400;
        run_phase(9'd16,  9'd16,  100, 1'b0);
        run_phase(9'd12,  9'd6,   80,  1'b1);
        run_phase(9'd4,   9'd2,   80,  1'b0);
        run_phase(9'd256, 9'd256, 290, 1'b0);
        run_phase(9'd511, 9'd3,   300, 1'b1);
        run_phase(9'd7,   9'd511, 60,  1'b0);
        drain(20);

        $display("summary: %0d samples (%0d with restart), %0d window sums checked",
                 sb.n_samples, sb.n_restarts, sb.n_sums);
        $display("summary: %0d register settings, windows 0 to 511, counts 0 to 511",
                 n_settings);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/wkss_pkg.sv
rtl/core/wkss_if.sv
rtl/core/wkss_ring.sv
rtl/core/wkss_cell.sv
rtl/core/window_k_smallest_sum_top.sv
sim/tb.sv
